@@ rtl/q6_q8_superblock_dot_product_unit_defines.svh @@
// Assertion macros for the Q6/Q8 super-block dot product checker.
// No dependencies; included by the checker file.
`ifndef Q6_Q8_SUPERBLOCK_DOT_PRODUCT_UNIT_DEFINES_SVH
`define Q6_Q8_SUPERBLOCK_DOT_PRODUCT_UNIT_DEFINES_SVH

// Check on every clock edge outside reset.
`define Q6Q8_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Check on every clock edge, reset included.
`define Q6Q8_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/q6q8_pkg.sv @@
// Shared types, widths and the weight decode for the Q6/Q8 dot product.
// No dependencies; used by every module of the block.
package q6q8_pkg;

	localparam int LANES   = 4;
	localparam int DATA_W  = 8;
	localparam int W_W     = 6;
	localparam int SW_W    = 14;
	localparam int PROD_W  = SW_W + DATA_W;
	localparam int TERM_W  = 20;
	localparam int SUM4_W  = TERM_W + 2;
	localparam int SUM_W   = 29;
	localparam int IN_W    = 88;
	localparam int OUT_W   = 32;
	localparam int ACT_LSB = 24;
	localparam int SCL_LSB = 56;

	typedef struct packed {
		logic valid;
		logic last;
	} ctl_t;

	// Code minus 32 is the code with its top bit inverted, read as signed.
	function automatic logic signed [W_W-1:0] weight6(input logic [3:0] nib,
			input logic [1:0] hi2);
		weight6 = {~hi2[1], hi2[0], nib};
	endfunction

endpackage

@@ rtl/q6_q8_superblock_dot_product_unit.sv @@
// Channel  | direction | payload
// s_axis   | in        | tdata: low_nibbles_a, low_nibbles_b, high_bits, act_0..3,
//          |           |        scale_0..3; tlast: block_end
// m_axis   | out       | tdata: block_dot (29 bits, zero padded to 32)
// One item per cycle while m_axis is not stalled; a result is valid once the item
// marked last has passed the four registers of the two multiply stages of the
// lanes, the lane sum and the result. Reset clears the accumulator and all valid flags.
// A result held on m_axis stalls the whole pipeline, and s_axis with it.
// Top level of the Q6/Q8 super-block dot product; depends on q6q8_pkg,
// q6q8_lane and q6q8_merge.
module q6_q8_superblock_dot_product_unit (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	// low_nibbles_a, low_nibbles_b, high_bits, act_0, act_1, act_2, act_3,
	// scale_0, scale_1, scale_2, scale_3
	input  logic [q6q8_pkg::IN_W-1:0]      s_axis_tdata,
	input  logic                           s_axis_tlast,
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	// block_dot, then zero padding
	output logic [q6q8_pkg::OUT_W-1:0]     m_axis_tdata
);

	logic                                en;
	q6q8_pkg::ctl_t                      ctl_s1;
	q6q8_pkg::ctl_t                      ctl_s2;
	logic signed [q6q8_pkg::TERM_W-1:0]  term [q6q8_pkg::LANES];
	logic [q6q8_pkg::DATA_W-1:0]         lna;
	logic [q6q8_pkg::DATA_W-1:0]         lnb;
	logic [q6q8_pkg::DATA_W-1:0]         hib;
	logic [3:0]                          nib [q6q8_pkg::LANES];
	logic [q6q8_pkg::SUM_W-1:0]          dot;

	assign en            = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = en;

	assign lna = s_axis_tdata[7:0];
	assign lnb = s_axis_tdata[15:8];
	assign hib = s_axis_tdata[23:16];

	assign nib[0] = lna[3:0];
	assign nib[1] = lnb[3:0];
	assign nib[2] = lna[7:4];
	assign nib[3] = lnb[7:4];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
		end else if (en) begin
			ctl_s1 <= '{valid: s_axis_tvalid, last: s_axis_tlast};
			ctl_s2 <= ctl_s1;
		end
	end

	for (genvar i = 0; i < q6q8_pkg::LANES; i++) begin : g_lane
		q6q8_lane u_lane (
			.clk   (clk),
			.en    (en),
			.nib   (nib[i]),
			.hi2   (hib[2*i +: 2]),
			.scale (s_axis_tdata[q6q8_pkg::SCL_LSB + q6q8_pkg::DATA_W*i +: q6q8_pkg::DATA_W]),
			.act   (s_axis_tdata[q6q8_pkg::ACT_LSB + q6q8_pkg::DATA_W*i +: q6q8_pkg::DATA_W]),
			.term  (term[i])
		);
	end

	q6q8_merge u_merge (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.ctl_s2    (ctl_s2),
		.term      (term),
		.out_valid (m_axis_tvalid),
		.out_data  (dot)
	);

	assign m_axis_tdata = {{(q6q8_pkg::OUT_W - q6q8_pkg::SUM_W){1'b0}}, dot};

endmodule

@@ rtl/q6q8_lane.sv @@
// One multiply lane: decodes a 6-bit weight and forms scale * weight * activation.
// Depends on q6q8_pkg.
module q6q8_lane (
	input  logic                                 clk,
	input  logic                                 en,
	input  logic [3:0]                           nib,
	input  logic [1:0]                           hi2,
	input  logic signed [q6q8_pkg::DATA_W-1:0]   scale,
	input  logic signed [q6q8_pkg::DATA_W-1:0]   act,
	output logic signed [q6q8_pkg::TERM_W-1:0]   term
);

	logic signed [q6q8_pkg::W_W-1:0]    w;
	logic signed [q6q8_pkg::SW_W-1:0]   sw;
	logic signed [q6q8_pkg::SW_W-1:0]   sw_s1;
	logic signed [q6q8_pkg::DATA_W-1:0] act_s1;
	logic signed [q6q8_pkg::PROD_W-1:0] prod;
	logic signed [q6q8_pkg::TERM_W-1:0] term_s2;

	assign w    = q6q8_pkg::weight6(nib, hi2);
	assign sw   = q6q8_pkg::SW_W'(scale) * q6q8_pkg::SW_W'(w);
	assign prod = q6q8_pkg::PROD_W'(sw_s1) * q6q8_pkg::PROD_W'(act_s1);

	always_ff @(posedge clk) begin
		if (en) begin
			sw_s1   <= sw;
			act_s1  <= act;
			term_s2 <= prod[q6q8_pkg::TERM_W-1:0];
		end
	end

	assign term = term_s2;

endmodule

@@ rtl/q6q8_merge.sv @@
// Merge stage: sums the lane terms, accumulates over the super-block, holds the result.
// Depends on q6q8_pkg.
module q6q8_merge (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                en,
	input  q6q8_pkg::ctl_t                      ctl_s2,
	input  logic signed [q6q8_pkg::TERM_W-1:0]  term [q6q8_pkg::LANES],
	output logic                                out_valid,
	output logic [q6q8_pkg::SUM_W-1:0]          out_data
);

	localparam int EXT_W = q6q8_pkg::SUM_W - q6q8_pkg::SUM4_W;

	logic signed [q6q8_pkg::SUM4_W-1:0] sum4;
	logic signed [q6q8_pkg::SUM4_W-1:0] sum_s3;
	q6q8_pkg::ctl_t                     ctl_s3;
	logic [q6q8_pkg::SUM_W-1:0]         acc_q;
	logic [q6q8_pkg::SUM_W-1:0]         total;
	logic                               out_valid_q;
	logic [q6q8_pkg::SUM_W-1:0]         out_data_q;

	always_comb begin
		sum4 = '0;
		for (int i = 0; i < q6q8_pkg::LANES; i++) begin
			sum4 = sum4 + q6q8_pkg::SUM4_W'(term[i]);
		end
	end

	assign total = acc_q + {{EXT_W{sum_s3[q6q8_pkg::SUM4_W-1]}}, sum_s3};

	always_ff @(posedge clk) begin
		if (en) begin
			sum_s3 <= sum4;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s3      <= '0;
			acc_q       <= '0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			ctl_s3      <= ctl_s2;
			out_valid_q <= ctl_s3.valid && ctl_s3.last;
			if (ctl_s3.valid) begin
				acc_q <= ctl_s3.last ? '0 : total;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en && ctl_s3.valid && ctl_s3.last) begin
			out_data_q <= total;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

@@ rtl/q6q8_checker.sv @@
// Port-level checks for the Q6/Q8 super-block dot product, bound to the top level.
// Depends on q6q8_pkg and the assertion macros header.
`include "q6_q8_superblock_dot_product_unit_defines.svh"

module q6q8_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        s_axis_tready,
	input logic                        m_axis_tvalid,
	input logic                        m_axis_tready,
	input logic [q6q8_pkg::OUT_W-1:0]  m_axis_tdata
);

	`Q6Q8_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata), "result dropped or changed while stalled")
	`Q6Q8_ASSERT(a_ready_follows_out, s_axis_tready == (!m_axis_tvalid || m_axis_tready), "input ready does not follow output stall")
	`Q6Q8_ASSERT(a_pad_zero, m_axis_tvalid |-> m_axis_tdata[q6q8_pkg::OUT_W-1:q6q8_pkg::SUM_W] == '0, "result padding not zero")
	`Q6Q8_ASSERT_ALWAYS(a_reset_quiet, !arst_n |=> !m_axis_tvalid, "result valid during reset")
	`Q6Q8_ASSERT(a_no_early_out, $rose(arst_n) |-> !m_axis_tvalid, "result valid right after reset")

endmodule

bind q6_q8_superblock_dot_product_unit q6q8_checker u_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);
